// ===== src/link_output_buffer_flow_control_core_macros.svh =====
// assertion macros used by the checker file
`ifndef LINK_OUTPUT_BUFFER_FLOW_CONTROL_CORE_MACROS_SVH
`define LINK_OUTPUT_BUFFER_FLOW_CONTROL_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LOBFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LOBFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lobfc_pkg.sv =====
// types and codes of the link output buffer
`default_nettype none
package lobfc_pkg;

    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_DONE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_LIMIT = 2'd3;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_FC   = 2'd1;
    localparam logic [1:0] KIND_FREE = 2'd2;
    localparam logic [1:0] KIND_OVF  = 2'd3;

    localparam logic CFG_MAX_VL      = 1'b0;
    localparam logic CFG_QUEUE_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  vl;
        logic [5:0]  credit_sn;
        logic [6:0]  packet_credits;
        logic [15:0] tag;
        logic [11:0] credit_limit;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_vl;
        logic [15:0] out_tag;
        logic [5:0]  out_credit_sn;
        logic [6:0]  out_packet_credits;
        logic [11:0] fc_limit;
        logic [11:0] fc_blocks_sent;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [3:0]  vl;
        logic [5:0]  credit_sn;
        logic [6:0]  packet_credits;
        logic [15:0] tag;
    } t_entry;

    typedef struct packed {
        logic [11:0] limit;
        logic [11:0] blocks;
        logic [11:0] last_sent;
    } t_lane;

endpackage
`default_nettype wire

// ===== src/lobfc_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module lobfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire  [$clog2(DEPTH)-1:0]        i_waddr,
    input  wire  [WIDTH-1:0]                i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]        i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/link_output_buffer_flow_control_core.sv =====
// link output buffer with credit queue and per-lane flow control
// a data credit on an idle link is sent through S_SEND; an overflow is reported from idle
// link done: the scan of lanes sends a flow-control packet, else a queued credit is popped
// and sent, else a lone free notice goes out; a pending free notice precedes the send
// one transaction at a time
// reset: synchronous active low, clears control state and lane valid flags; no clearing pass
`default_nettype none
module link_output_buffer_flow_control_core #(
    parameter int QUEUE_DEPTH = 32,
    parameter int NUM_LANES   = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire  lobfc_pkg::t_item   i_item,
    output logic                 o_busy,
    output logic                 o_strobe,
    output lobfc_pkg::t_result   o_result,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_addr,
    input  wire  [5:0]           i_cfg_wdata
);
    import lobfc_pkg::*;

    localparam int LW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
    localparam int SW = LW + 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(t_entry);
    localparam int LNW = $bits(t_lane);

    typedef enum logic [2:0] {
        S_IDLE, S_LIMIT, S_SCAN, S_POP, S_SEND, S_EMIT2
    } t_state;

    t_state        r_state;
    t_entry        r_ent;
    logic          r_is_pop;
    logic [11:0]   r_limit_in;
    logic [QW-1:0] r_head;
    logic [QW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic          r_link_busy;
    logic          r_inside;
    logic          r_lpwd;
    logic [SW-1:0] r_scan;
    logic          r_mtp;
    logic          r_pend_free;
    logic          r_lsv  [NUM_LANES];
    logic          r_init [NUM_LANES];
    logic [3:0]    r_max_vl;
    logic [5:0]    r_qlim;
    t_result       r_out;
    logic          r_out_valid;
    t_result       r_hold;
    logic [LW-1:0] r_lane_ra;
    logic          r_lane_ok;

    // ram ports
    logic          lane_we;
    logic [LW-1:0] lane_wa;
    t_lane         lane_wd;
    logic [LW-1:0] lane_ra;
    logic          lane_ra_ok;
    logic [LNW-1:0] lane_rd;
    logic          q_we;
    t_entry        q_wd;
    logic [EW-1:0] q_rd;

    logic          w_accept;
    logic [3:0]    w_top;
    logic          w_full;
    logic          w_fc_ok;
    t_lane         w_lane;
    logic          w_due;
    logic          w_scan_top;
    logic          w_scan_more;
    logic [SW-1:0] w_scan_nx;
    t_entry        w_in_ent;
    t_entry        w_pop;
    t_result       w_res_credit;
    t_result       w_res_fc;

    function automatic logic lane_in_range(input logic [4:0] v);
        return v < 5'(NUM_LANES);
    endfunction

    function automatic t_result mk_credit(input logic [1:0] k, input t_entry e);
        t_result r;
        r = '0;
        r.kind = k;
        r.out_vl = e.vl;
        r.out_tag = e.tag;
        r.out_credit_sn = e.credit_sn;
        r.out_packet_credits = e.packet_credits;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_result mk_free(input logic l);
        t_result r;
        r = '0;
        r.kind = KIND_FREE;
        r.last = l;
        return r;
    endfunction

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_top = (r_max_vl > 4'(NUM_LANES - 1)) ? 4'(NUM_LANES - 1) : r_max_vl;
    // effective limit is queue_limit capped at the queue depth
    assign w_full = (32'(r_count) >= ((32'(r_qlim) > QUEUE_DEPTH) ? QUEUE_DEPTH
                                                                   : 32'(r_qlim)));
    assign w_fc_ok = !r_inside && (r_mtp || (r_count == '0))
                     && (5'(r_scan) <= 5'(w_top));
    // a lane entry never written since reset reads as zero
    assign w_lane = (r_lane_ok && r_init[r_lane_ra]) ? t_lane'(lane_rd) : '0;
    assign w_due = !r_lsv[r_lane_ra] || (w_lane.last_sent != w_lane.blocks);
    assign w_scan_nx = SW'(r_scan + 1'b1);
    assign w_scan_top = (5'(r_scan) == 5'(w_top));
    assign w_scan_more = !w_due && (5'(w_scan_nx) <= 5'(w_top));
    assign w_pop = t_entry'(q_rd);

    always_comb begin
        w_in_ent.vl = i_item.vl;
        w_in_ent.credit_sn = i_item.credit_sn;
        w_in_ent.packet_credits = i_item.packet_credits;
        w_in_ent.tag = i_item.tag;
    end

    // a sent credit or flow-control packet is always the final result
    always_comb begin
        w_res_credit = mk_credit(KIND_DATA, r_ent);
        w_res_fc = '0;
        w_res_fc.kind = KIND_FC;
        w_res_fc.out_vl = 4'(r_scan);
        w_res_fc.fc_limit = w_lane.limit;
        w_res_fc.fc_blocks_sent = w_lane.blocks;
        w_res_fc.last = 1'b1;
    end

    // lane ram read address follows the step that needs the data next cycle
    always_comb begin
        case (r_state)
            S_IDLE: begin
                if (i_item.op == OP_DONE) begin
                    lane_ra = r_scan[LW-1:0];
                    lane_ra_ok = lane_in_range(5'(r_scan));
                end else begin
                    lane_ra = i_item.vl[LW-1:0];
                    lane_ra_ok = lane_in_range({1'b0, i_item.vl});
                end
            end
            S_SCAN: begin
                lane_ra = w_scan_nx[LW-1:0];
                lane_ra_ok = lane_in_range(5'(w_scan_nx));
            end
            S_POP: begin
                lane_ra = w_pop.vl[LW-1:0];
                lane_ra_ok = lane_in_range({1'b0, w_pop.vl});
            end
            default: begin
                lane_ra = r_lane_ra;
                lane_ra_ok = 1'b0;
            end
        endcase
    end

    // lane ram write: read-modify-write of the entry fetched the cycle before
    always_comb begin
        lane_we = 1'b0;
        lane_wa = r_lane_ra;
        lane_wd = w_lane;
        case (r_state)
            S_LIMIT: begin
                lane_we = r_lane_ok;
                lane_wd.limit = r_limit_in;
            end
            S_SCAN: begin
                lane_we = w_due;
                lane_wd.last_sent = w_lane.blocks;
            end
            S_SEND: begin
                lane_we = r_lane_ok;
                lane_wd.blocks = w_lane.blocks + 12'd1;
            end
            default: lane_we = 1'b0;
        endcase
    end

    assign q_we = w_accept && (i_item.op == OP_DATA) && r_link_busy && !w_full;
    assign q_wd = w_in_ent;

    lobfc_ram #(.WIDTH(LNW), .DEPTH(NUM_LANES)) u_lane_ram (
        .i_clk   (i_clk),
        .i_we    (lane_we),
        .i_waddr (lane_wa),
        .i_wdata (lane_wd),
        .i_raddr (lane_ra),
        .o_rdata (lane_rd)
    );

    lobfc_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (q_wd),
        .i_raddr (r_head),
        .o_rdata (q_rd)
    );

    always_ff @(posedge i_clk) begin
        r_lane_ra <= lane_ra;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
            r_link_busy <= 1'b0;
            r_inside <= 1'b0;
            r_lpwd <= 1'b0;
            r_scan <= '0;
            r_mtp <= 1'b0;
            r_pend_free <= 1'b0;
            r_is_pop <= 1'b0;
            r_lane_ok <= 1'b0;
            r_max_vl <= 4'd7;
            r_qlim <= 6'd32;
            for (int i = 0; i < NUM_LANES; i++) begin
                r_lsv[i] <= 1'b0;
                r_init[i] <= 1'b0;
            end
        end else begin
            r_lane_ok <= lane_ra_ok;
            if (lane_we) begin
                r_init[lane_wa] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAX_VL:      r_max_vl <= i_cfg_wdata[3:0];
                    CFG_QUEUE_LIMIT: r_qlim <= i_cfg_wdata;
                    default:         r_qlim <= r_qlim;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_item.op)
                            OP_DATA: begin
                                r_pend_free <= 1'b0;
                                r_ent <= w_in_ent;
                                r_is_pop <= 1'b0;
                                if (!r_link_busy) begin
                                    r_out_valid <= 1'b0;
                                    r_state <= S_SEND;
                                end else if (w_full) begin
                                    // dropped, state unchanged
                                    r_out <= mk_credit(KIND_OVF, w_in_ent);
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_out_valid <= 1'b0;
                                    r_tail <= (32'(r_tail) == QUEUE_DEPTH - 1) ? '0
                                                                              : QW'(r_tail + 1'b1);
                                    r_count <= CW'(r_count + 1'b1);
                                end
                            end
                            OP_DONE: begin
                                r_link_busy <= 1'b0;
                                r_pend_free <= r_lpwd;
                                if (w_fc_ok) begin
                                    r_out_valid <= 1'b0;
                                    r_state <= S_SCAN;
                                end else if (r_count != '0) begin
                                    r_out_valid <= 1'b0;
                                    r_state <= S_POP;
                                end else begin
                                    r_lpwd <= 1'b0;
                                    r_out_valid <= r_lpwd;
                                    if (r_lpwd) begin
                                        r_out <= mk_free(1'b1);
                                    end
                                end
                            end
                            OP_TICK: begin
                                r_out_valid <= 1'b0;
                                r_scan <= '0;
                                r_mtp <= 1'b1;
                                r_link_busy <= 1'b1;
                            end
                            OP_LIMIT: begin
                                r_out_valid <= 1'b0;
                                r_limit_in <= i_item.credit_limit;
                                if (lane_in_range({1'b0, i_item.vl})) begin
                                    r_state <= S_LIMIT;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end else begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_LIMIT: begin
                    r_out_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (w_scan_top) begin
                        r_mtp <= 1'b0;
                    end
                    r_scan <= w_scan_nx;
                    if (w_due) begin
                        r_lsv[r_lane_ra] <= 1'b1;
                        r_link_busy <= 1'b1;
                        r_lpwd <= 1'b0;
                        r_out_valid <= 1'b1;
                        if (r_pend_free) begin
                            r_out <= mk_free(1'b0);
                            r_hold <= w_res_fc;
                            r_state <= S_EMIT2;
                        end else begin
                            r_out <= w_res_fc;
                            r_state <= S_IDLE;
                        end
                    end else if (!w_scan_more) begin
                        if (r_count != '0) begin
                            r_out_valid <= 1'b0;
                            r_state <= S_POP;
                        end else begin
                            r_lpwd <= 1'b0;
                            r_state <= S_IDLE;
                            r_out_valid <= r_pend_free;
                            if (r_pend_free) begin
                                r_out <= mk_free(1'b1);
                            end
                        end
                    end else begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_POP: begin
                    r_out_valid <= 1'b0;
                    r_ent <= w_pop;
                    r_is_pop <= 1'b1;
                    r_head <= (32'(r_head) == QUEUE_DEPTH - 1) ? '0 : QW'(r_head + 1'b1);
                    r_count <= CW'(r_count - 1'b1);
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    r_link_busy <= 1'b1;
                    if ((r_ent.credit_sn == 6'd0) && (r_ent.packet_credits > 7'd1)) begin
                        r_inside <= 1'b1;
                    end else if ((7'(r_ent.credit_sn) + 7'd1) == r_ent.packet_credits) begin
                        r_inside <= 1'b0;
                    end
                    if (r_is_pop) begin
                        r_lpwd <= 1'b1;
                    end
                    r_out_valid <= 1'b1;
                    if (r_pend_free) begin
                        r_out <= mk_free(1'b0);
                        r_hold <= w_res_credit;
                        r_state <= S_EMIT2;
                    end else begin
                        r_out <= w_res_credit;
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT2: begin
                    r_out <= r_hold;
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_out_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_strobe = r_out_valid;
    assign o_result = r_out;
endmodule
`default_nettype wire

// ===== src/lobfc_checker.sv =====
// port level checks of the link output buffer
`default_nettype none
`include "link_output_buffer_flow_control_core_macros.svh"
module lobfc_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_busy,
    input wire                 i_strobe,
    input wire lobfc_pkg::t_result i_result
);
    import lobfc_pkg::*;

    `LOBFC_ASSERT_NXT(a_second_follows, i_clk, i_rst_n, i_strobe && !i_result.last, i_strobe, "result without last not followed")
    `LOBFC_ASSERT_NXT(a_free_then_send, i_clk, i_rst_n, i_strobe && !i_result.last && (i_result.kind == KIND_FREE), i_strobe && ((i_result.kind == KIND_DATA) || (i_result.kind == KIND_FC)), "free notice not followed by a send")
    `LOBFC_ASSERT_IMP(a_ovf_last, i_clk, i_rst_n, i_strobe && (i_result.kind == KIND_OVF), i_result.last, "overflow not final")
    `LOBFC_ASSERT_IMP(a_busy_mid, i_clk, i_rst_n, i_strobe && !i_result.last, i_busy, "not busy between results")
endmodule

bind link_output_buffer_flow_control_core lobfc_checker u_lobfc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_busy   (o_busy),
    .i_strobe (o_strobe),
    .i_result (o_result)
);
`default_nettype wire
